/* sv/nff_pkg.sv */
// Shared types, constants and checksum helper for the nibble flag framer.
package nff_pkg;

   // Line constants
   localparam logic [3:0] FlagHi      = 4'b0111;
   localparam logic [3:0] FlagLo      = 4'b1110;
   localparam logic [3:0] StuffTrig   = 4'b0111;
   localparam logic [3:0] StuffNibble = 4'b0011;
   localparam logic [8:0] Modulus     = 9'd137;

   // Most line words that one input word can produce
   localparam int MaxWords = 8;
   localparam int CntW     = $clog2(MaxWords + 1);
   localparam int IdxW     = $clog2(MaxWords);

   typedef struct packed {
      logic [3:0] payload_nibble;
      logic       end_of_payload;
   } req_type;

   typedef struct packed {
      logic [3:0] line_nibble;
      logic       frame_done;
   } rsp_type;

   // Builder output: the line words for one input word plus the next state
   typedef struct packed {
      rsp_type [MaxWords-1:0] words;
      logic [CntW-1:0]        count;
      logic                   inside_frame;
      logic [7:0]             running_residue;
   } build_type;

   // Add a nibble to the residue, modulo 137 (residue stays below 137)
   function automatic logic [7:0] add_mod(input logic [7:0] residue, input logic [3:0] nib);
      logic [8:0] sum;
      sum = {1'b0, residue} + {5'b0, nib};
      if (sum >= Modulus) begin
         sum = sum - Modulus;
      end
      return sum[7:0];
   endfunction

endpackage

/* sv/nff_builder.sv */
// Combinational expansion of one payload word into its list of line words.
module nff_builder (
   input  nff_pkg::req_type   item,
   input  logic               inside_frame,
   input  logic [7:0]         running_residue,
   output nff_pkg::build_type build
);

   always_comb begin
      logic [nff_pkg::CntW-1:0] k;
      logic [7:0]               res;
      build = '0;
      k     = '0;
      res   = running_residue;

      // start flag when a frame opens
      if (!inside_frame) begin
         build.words[k[nff_pkg::IdxW-1:0]] = '{line_nibble: nff_pkg::FlagHi, frame_done: 1'b0};
         k = k + 1'b1;
         build.words[k[nff_pkg::IdxW-1:0]] = '{line_nibble: nff_pkg::FlagLo, frame_done: 1'b0};
         k = k + 1'b1;
         res = '0;
      end

      // payload nibble, then stuffing after 0111
      build.words[k[nff_pkg::IdxW-1:0]] = '{line_nibble: item.payload_nibble, frame_done: 1'b0};
      k = k + 1'b1;
      res = nff_pkg::add_mod(res, item.payload_nibble);
      if (item.payload_nibble == nff_pkg::StuffTrig) begin
         build.words[k[nff_pkg::IdxW-1:0]] =
            '{line_nibble: nff_pkg::StuffNibble, frame_done: 1'b0};
         k = k + 1'b1;
         res = nff_pkg::add_mod(res, nff_pkg::StuffNibble);
      end

      // checksum and end flag close the frame
      if (item.end_of_payload) begin
         build.words[k[nff_pkg::IdxW-1:0]] = '{line_nibble: res[7:4], frame_done: 1'b0};
         k = k + 1'b1;
         build.words[k[nff_pkg::IdxW-1:0]] = '{line_nibble: res[3:0], frame_done: 1'b0};
         k = k + 1'b1;
         build.words[k[nff_pkg::IdxW-1:0]] = '{line_nibble: nff_pkg::FlagHi, frame_done: 1'b0};
         k = k + 1'b1;
         build.words[k[nff_pkg::IdxW-1:0]] = '{line_nibble: nff_pkg::FlagLo, frame_done: 1'b1};
         k = k + 1'b1;
         build.inside_frame    = 1'b0;
         build.running_residue = '0;
      end else begin
         build.inside_frame    = 1'b1;
         build.running_residue = res;
      end
      build.count = k;
   end

endmodule

/* sv/nibble_flag_framer_with_stuffing.sv */
// Top level: nibble framer with flags, 0111 stuffing and modulo-137 checksum.
//
// Payload nibbles enter on req_, one word per cycle unless req_stall is high,
// into an input register. Each word is expanded in one pass into a list of
// line words (start flag, the nibble, a 0011 stuffing nibble after 0111, and
// at frame end the two checksum nibbles and the end flag), loaded into an
// output list and sent on rsp_ one word per cycle unless rsp_stall is high.
// Mid-frame a payload word yields one line word (two if stuffed), so without
// stalls the block sustains one payload word per cycle less the stuffing;
// opening and closing words add flag and checksum words on the list's single
// output port. Words pass the input register, then the output list, to rsp_.
module nibble_flag_framer_with_stuffing (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  nff_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output nff_pkg::rsp_type rsp_data
);

   // input register
   logic             in_valid_ff, in_valid_in;
   nff_pkg::req_type in_data_ff, in_data_in;

   // framing state
   logic       inside_ff, inside_in;
   logic [7:0] residue_ff, residue_in;

   // output list
   nff_pkg::rsp_type [nff_pkg::MaxWords-1:0] words_ff, words_in;
   logic [nff_pkg::CntW-1:0]                 cnt_ff, cnt_in;

   nff_pkg::build_type build;
   logic               take, move;

   nff_builder u_builder (
      .item            (in_data_ff),
      .inside_frame    (inside_ff),
      .running_residue (residue_ff),
      .build           (build)
   );

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = words_ff[0];
   assign take      = rsp_valid && !rsp_stall;

   // load the list when it is empty or its last word leaves this cycle
   assign move = in_valid_ff &&
                 ((cnt_ff == '0) || ((cnt_ff == nff_pkg::CntW'(1)) && take));

   assign req_stall = in_valid_ff && !move;

   // input register next state
   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (move) begin
         in_valid_in = 1'b0;
      end
   end

   // list and framing state next values
   always_comb begin
      words_in   = words_ff;
      cnt_in     = cnt_ff;
      inside_in  = inside_ff;
      residue_in = residue_ff;
      if (move) begin
         words_in   = build.words;
         cnt_in     = build.count;
         inside_in  = build.inside_frame;
         residue_in = build.running_residue;
      end else if (take) begin
         for (int i = 0; i < nff_pkg::MaxWords - 1; i++) begin
            words_in[i] = words_ff[i+1];
         end
         words_in[nff_pkg::MaxWords-1] = '0;
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         cnt_ff      <= '0;
         inside_ff   <= 1'b0;
         residue_ff  <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         cnt_ff      <= cnt_in;
         inside_ff   <= inside_in;
         residue_ff  <= residue_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      words_ff   <= words_in;
   end

endmodule
